// ===== src/block_bitmap_allocator_defines.svh =====
// Assertion macros shared by the block bitmap allocator RTL.
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BBA_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication.
`define BBA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define BBA_ASSERT(lbl, clk, rst, ante, cons)
`define BBA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/bba_pkg.sv =====
// Types, constants and scan helpers for the block bitmap allocator.
package bba_pkg;

  localparam int MAX_BLOCKS  = 8192;
  localparam int WORD_BITS   = 32;
  localparam int WORD_COUNT  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int BNUM_W      = WIDX_W + BIT_W;
  localparam int BLK_W       = 13;
  localparam int CNT_W       = 14;
  localparam int CMP_W       = ((BNUM_W > CNT_W) ? BNUM_W : CNT_W) + 1;
  localparam int GROUP_SIZE  = 16;
  localparam int GOFF_W      = $clog2(GROUP_SIZE);
  localparam int GROUP_COUNT = (WORD_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GIDX_W      = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int PAD_WORDS   = GROUP_COUNT * GROUP_SIZE;

  localparam logic [CNT_W-1:0] USABLE_RESET = CNT_W'(8192);

  // Register index decoded from paddr[2].
  localparam logic REG_USABLE_BLOCKS = 1'b0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_FULL         = 2'd1,
    STAT_ALREADY_FREE = 2'd2,
    STAT_RANGE        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_READ,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic scan;
    logic pick;
    logic read;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic op_free;
    logic out_free;
  } dp_sts_t;

  // {found, index} of the lowest zero bit in a group of summary flags.
  function automatic logic [GOFF_W:0] first_zero_group(input logic [GROUP_SIZE-1:0] v);
    logic [GOFF_W:0] res;
    res = '0;
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (!v[i]) res = {1'b1, GOFF_W'(i)};
    end
    return res;
  endfunction

  // {found, index} of the lowest set group flag.
  function automatic logic [GIDX_W:0] first_one_group(input logic [GROUP_COUNT-1:0] v);
    logic [GIDX_W:0] res;
    res = '0;
    for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
      if (v[i]) res = {1'b1, GIDX_W'(i)};
    end
    return res;
  endfunction

  // {found, index} of the lowest zero bit in a bitmap word.
  function automatic logic [BIT_W:0] first_zero_word(input logic [WORD_BITS-1:0] v);
    logic [BIT_W:0] res;
    res = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) res = {1'b1, BIT_W'(i)};
    end
    return res;
  endfunction

endpackage

// ===== src/bba_ctrl.sv =====
// Sequencer for the block bitmap allocator.
`include "block_bitmap_allocator_defines.svh"

module bba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bba_pkg::dp_sts_t sts,
  output bba_pkg::dp_cmd_t cmd
);
  import bba_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        state_next = sts.op_free ? S_READ : S_PICK;
      end
      S_PICK: begin
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
      end
      S_READ: begin
        cmd.read = 1'b1;
      end
      S_UPDATE: begin
        cmd.update = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `BBA_ASSERT(a_update_needs_slot, clk, rst, cmd.update, sts.out_free)
  `BBA_ASSERT(a_single_cmd, clk, rst, 1'b1, $onehot0(cmd))
  `BBA_ASSERT_NXT(a_read_then_update, clk, rst, cmd.read, state == S_UPDATE)

endmodule

// ===== src/bba_datapath.sv =====
// Bitmap storage, word-full summary scan and result register.
`include "block_bitmap_allocator_defines.svh"

module bba_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::dp_cmd_t              cmd,
  output bba_pkg::dp_sts_t              sts,
  input  logic                          operation,
  input  logic [bba_pkg::BLK_W-1:0]     block_number,
  input  logic [bba_pkg::CNT_W-1:0]     usable_blocks,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [bba_pkg::BLK_W-1:0]     granted_block,
  output logic [1:0]                    status
);
  import bba_pkg::*;

  // item registers
  logic                 op_free;
  logic [BLK_W-1:0]     blk;
  logic [WIDX_W-1:0]    addr;
  logic                 scan_found;

  // bitmap words, per-word valid (reset clears) and full summary
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] mem_q;
  logic                 word_valid_q;
  logic [WORD_COUNT-1:0] word_valid;
  logic [WORD_COUNT-1:0] full;

  // scan tree
  logic [PAD_WORDS-1:0]  full_pad;
  logic [GROUP_COUNT-1:0] grp_any_c;
  logic [GOFF_W-1:0]     grp_first_c [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] grp_any;
  logic [GOFF_W-1:0]     grp_first [GROUP_COUNT];
  logic [GIDX_W:0]       pick_res;
  logic [GIDX_W+GOFF_W-1:0] pick_word;

  // update logic
  logic [CMP_W-1:0]     usable_ext;
  logic [CMP_W-1:0]     limit;
  logic [CMP_W-1:0]     blk_ext;
  logic [CMP_W-1:0]     cand;
  logic [WORD_BITS-1:0] word;
  logic [BIT_W:0]       zero_res;
  logic                 alloc_ok;
  logic                 in_range;
  logic                 cur_bit;
  logic                 free_ok;
  logic [WORD_BITS-1:0] new_word;
  logic                 do_write;
  status_t              res_status;
  logic [BLK_W-1:0]     res_granted;

  // result register
  status_t              status_q;
  logic [BLK_W-1:0]     granted_q;

  // stage one: lowest non-full word inside each group
  always_comb begin
    logic [GOFF_W:0] r;
    full_pad = '1;
    full_pad[WORD_COUNT-1:0] = full;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      r = first_zero_group(full_pad[g*GROUP_SIZE +: GROUP_SIZE]);
      grp_any_c[g]   = r[GOFF_W];
      grp_first_c[g] = r[GOFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      grp_any   <= grp_any_c;
      grp_first <= grp_first_c;
    end
  end

  // stage two: lowest group with a free word
  assign pick_res  = first_one_group(grp_any);
  assign pick_word = {pick_res[GIDX_W-1:0], grp_first[pick_res[GIDX_W-1:0]]};

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_free <= (operation == OP_FREE);
      blk     <= block_number;
      addr    <= WIDX_W'(block_number >> BIT_W);
    end else if (cmd.pick) begin
      addr       <= WIDX_W'(pick_word);
      scan_found <= pick_res[GIDX_W];
    end
  end

  // bitmap memory: registered read, write-back on update
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      mem_q <= mem[addr];
    end
    if (do_write) begin
      mem[addr] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      full       <= '0;
    end else if (do_write) begin
      word_valid[addr] <= 1'b1;
      full[addr]       <= &new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      word_valid_q <= word_valid[addr];
    end
  end

  // count above capacity acts as capacity
  assign usable_ext = CMP_W'(usable_blocks);
  assign limit = (usable_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : usable_ext;

  always_comb begin
    word     = word_valid_q ? mem_q : '0;
    zero_res = first_zero_word(word);
    cand     = CMP_W'({addr, zero_res[BIT_W-1:0]});
    alloc_ok = scan_found && zero_res[BIT_W] && (cand < limit);
    blk_ext  = CMP_W'(blk);
    in_range = blk_ext < limit;
    cur_bit  = word[blk[BIT_W-1:0]];
    free_ok  = in_range && cur_bit;
    if (op_free) begin
      new_word = word & ~(WORD_BITS'(1) << blk[BIT_W-1:0]);
    end else begin
      new_word = word | (WORD_BITS'(1) << zero_res[BIT_W-1:0]);
    end
    do_write = cmd.update && (op_free ? free_ok : alloc_ok);
    if (op_free) begin
      if (!in_range) res_status = STAT_RANGE;
      else if (!cur_bit) res_status = STAT_ALREADY_FREE;
      else res_status = STAT_OK;
      res_granted = '0;
    end else begin
      res_status  = alloc_ok ? STAT_OK : STAT_FULL;
      res_granted = alloc_ok ? cand[BLK_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      status_q  <= res_status;
      granted_q <= res_granted;
    end
  end

  assign granted_block = granted_q;
  assign status        = status_q;
  assign sts.op_free   = op_free;
  assign sts.out_free  = !out_valid || !out_stall;

  `BBA_ASSERT(a_no_grant_on_error, clk, rst, out_valid && status_q != STAT_OK, granted_q == '0)
  `BBA_ASSERT_NXT(a_free_clears_full, clk, rst, do_write && op_free, !full[$past(addr)])
  `BBA_ASSERT_NXT(a_stalled_result_held, clk, rst, out_valid && out_stall, out_valid)

endmodule

// ===== src/block_bitmap_allocator.sv =====
// Sequence: an allocate result follows the accepted beat via scan, pick, read and update;
//   a free result via scan, read and update. One item in flight at a time.
// Throughput: a new request is accepted only after the current item is done (in_stall high),
//   set by the two-stage summary scan, the bitmap read-modify-write and out_stall.
// Reset (rst, synchronous): every block free, usable_blocks = 8192, no result pending.
//   The bitmap is cleared by per-word valid flags, so no clearing pass is needed.
module block_bitmap_allocator (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [12:0] block_number,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] granted_block,
  output logic [1:0]  status,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bba_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [CNT_W-1:0]  usable_blocks;
  logic              cfg_write;

  // Only one register; paddr[2] selects it, other addresses read zero and ignore writes.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_USABLE_BLOCKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_blocks <= USABLE_RESET;
    end else if (cfg_write) begin
      usable_blocks <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_USABLE_BLOCKS) ? 32'(usable_blocks) : '0;

  // Controller sequences scan/pick/read/update; the datapath holds the bitmap.
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (operation),
    .block_number  (block_number),
    .usable_blocks (usable_blocks),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .granted_block (granted_block),
    .status        (status)
  );

endmodule
